// File: rtl/ultrasonic_echo_ranger_unit_assert.svh
// Assertion macros, clocked on clk and disabled while rst_n is low.
`ifndef ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define UER_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ranger check failed");

// Next-cycle implication.
`define UER_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ranger check failed");

`endif

// File: rtl/uer_pkg.sv
`default_nettype none
package uer_pkg;

  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 3;

  typedef logic [TIME_W-1:0] time_t;

  localparam logic [1:0] KIND_UPDATE = 2'd0;
  localparam logic [1:0] KIND_TICK = 2'd1;
  localparam logic [1:0] KIND_REQUEST = 2'd2;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_TRIGGER = 3'd1;
  localparam logic [2:0] PH_WAIT_RISE = 3'd2;
  localparam logic [2:0] PH_MEASURING = 3'd3;
  localparam logic [2:0] PH_COMPLETE = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISE_TIMEOUT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FALL_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RANGE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_RANGE = 3'd5;

  localparam logic [15:0] RST_MIN_INTERVAL = 16'd60;
  localparam logic [7:0] RST_RISE_TIMEOUT = 8'd5;
  localparam logic [7:0] RST_FALL_TIMEOUT = 8'd26;
  localparam logic [7:0] RST_SCALE = 8'd17;
  localparam logic [15:0] RST_MAX_RANGE = 16'd450;
  localparam logic [15:0] RST_MIN_RANGE = 16'd2;

  typedef struct packed {
    logic [15:0] min_interval_ms;
    logic [7:0]  rise_timeout_ms;
    logic [7:0]  fall_timeout_ms;
    logic [7:0]  scale_per_ms;
    logic [15:0] max_range;
    logic [15:0] min_range;
  } cfg_t;

  typedef struct packed {
    logic        big;
    logic [15:0] ms;
  } width_t;

endpackage
`default_nettype wire

// File: rtl/uer_in_if.sv
`default_nettype none
interface uer_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic       echo_level;

  modport source (output valid, output kind, output echo_level, input ready);
  modport sink (input valid, input kind, input echo_level, output ready);
endinterface
`default_nettype wire

// File: rtl/uer_out_if.sv
`default_nettype none
interface uer_out_if;
  logic        valid;
  logic        ready;
  logic        trigger_pulse;
  logic [15:0] distance_cm;
  logic        done_res;
  logic [2:0]  phase;

  modport source (output valid, output trigger_pulse, output distance_cm,
                  output done_res, output phase, input ready);
  modport sink (input valid, input trigger_pulse, input distance_cm,
                input done_res, input phase, output ready);
endinterface
`default_nettype wire

// File: rtl/uer_dist.sv
`default_nettype none
module uer_dist (
  input  wire uer_pkg::cfg_t   cfg,
  input  wire uer_pkg::width_t wid,
  output logic [15:0]          range_cm
);

  logic [23:0] prod;
  logic [23:0] raw;
  logic [23:0] clamped;

  assign prod = {8'd0, wid.ms} * {16'd0, cfg.scale_per_ms};

  always_comb begin
    if (wid.big) begin
      raw = (cfg.scale_per_ms == 8'd0) ? 24'd0 : {8'd0, cfg.max_range};
    end else begin
      raw = prod;
    end
    clamped = (raw > {8'd0, cfg.max_range}) ? {8'd0, cfg.max_range} : raw;
    range_cm = (clamped < {8'd0, cfg.min_range}) ? 16'd0 : clamped[15:0];
  end

endmodule
`default_nettype wire

// File: rtl/ultrasonic_echo_ranger_unit.sv
// An accepted request's result is registered directly into the output register.
// Throughput: one request per cycle; the output register holds a stalled result
// and the next request is taken in the cycle that result leaves.
// Reset: synchronous, active low; clears the phase to idle, all timers and the
// pending flag to zero and loads the register defaults. No clearing pass.
`default_nettype none
module ultrasonic_echo_ranger_unit (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 cfg_we,
  input  wire [uer_pkg::CFG_IDX_W-1:0]        cfg_idx,
  input  wire [uer_pkg::CFG_W-1:0]            cfg_data,
  uer_in_if.sink                              in_chan,
  uer_out_if.source                           out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE      = uer_pkg::PH_IDLE,
    ST_TRIGGER   = uer_pkg::PH_TRIGGER,
    ST_WAIT_RISE = uer_pkg::PH_WAIT_RISE,
    ST_MEASURING = uer_pkg::PH_MEASURING,
    ST_COMPLETE  = uer_pkg::PH_COMPLETE
  } state_t;

  uer_pkg::cfg_t   cfg_r;
  state_t          phase_r, phase_nxt;
  uer_pkg::time_t  now_r, now_nxt;
  uer_pkg::time_t  last_r, last_nxt;
  uer_pkg::time_t  rise_r, rise_nxt;
  uer_pkg::time_t  deadline_r, deadline_nxt;
  logic            pend_r, pend_nxt;
  logic [15:0]     dist_r, dist_nxt;
  uer_pkg::width_t width_r, width_nxt;
  logic            trig_nxt, done_nxt;

  logic            out_valid_r;
  logic            out_trig_r;
  logic            out_done_r;
  logic [15:0]     out_dist_r;
  logic [2:0]      out_phase_r;

  uer_pkg::time_t  elapsed;
  uer_pkg::time_t  width_full;
  logic            expired;
  logic            accept;
  logic [15:0]     calc_dist;

  uer_dist u_dist (
    .cfg      (cfg_r),
    .wid      (width_r),
    .range_cm (calc_dist)
  );

  assign in_chan.ready = ~out_valid_r | out_chan.ready;
  assign accept = in_chan.valid & in_chan.ready;

  assign elapsed = now_r - last_r;
  assign width_full = now_r - rise_r;
  assign expired = now_r > deadline_r;

  always_comb begin
    phase_nxt = phase_r;
    now_nxt = now_r;
    last_nxt = last_r;
    rise_nxt = rise_r;
    deadline_nxt = deadline_r;
    pend_nxt = pend_r;
    dist_nxt = dist_r;
    width_nxt = width_r;
    trig_nxt = 1'b0;
    done_nxt = 1'b0;
    if (accept) begin
      unique case (in_chan.kind)
        uer_pkg::KIND_TICK: begin
          now_nxt = now_r + uer_pkg::time_t'(1);
        end
        uer_pkg::KIND_REQUEST: begin
          if (phase_r == ST_IDLE) begin
            pend_nxt = 1'b1;
          end
        end
        uer_pkg::KIND_UPDATE: begin
          unique case (phase_r)
            ST_IDLE: begin
              if (pend_r && elapsed >= uer_pkg::time_t'(cfg_r.min_interval_ms)) begin
                phase_nxt = ST_TRIGGER;
                pend_nxt = 1'b0;
                last_nxt = now_r;
              end
            end
            ST_TRIGGER: begin
              trig_nxt = 1'b1;
              rise_nxt = '0;
              deadline_nxt = now_r + uer_pkg::time_t'(cfg_r.rise_timeout_ms);
              phase_nxt = ST_WAIT_RISE;
            end
            ST_WAIT_RISE: begin
              if (expired) begin
                phase_nxt = ST_IDLE;
                dist_nxt = 16'd0;
                done_nxt = 1'b1;
              end else if (in_chan.echo_level) begin
                rise_nxt = now_r;
                deadline_nxt = now_r + uer_pkg::time_t'(cfg_r.fall_timeout_ms);
                phase_nxt = ST_MEASURING;
              end
            end
            ST_MEASURING: begin
              if (expired || !in_chan.echo_level) begin
                width_nxt.big = (width_full >> 16) != '0;
                width_nxt.ms = width_full[15:0];
                phase_nxt = ST_COMPLETE;
              end
            end
            ST_COMPLETE: begin
              dist_nxt = calc_dist;
              done_nxt = 1'b1;
              phase_nxt = ST_IDLE;
            end
            default: begin
              phase_nxt = ST_IDLE;
            end
          endcase
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_interval_ms <= uer_pkg::RST_MIN_INTERVAL;
      cfg_r.rise_timeout_ms <= uer_pkg::RST_RISE_TIMEOUT;
      cfg_r.fall_timeout_ms <= uer_pkg::RST_FALL_TIMEOUT;
      cfg_r.scale_per_ms <= uer_pkg::RST_SCALE;
      cfg_r.max_range <= uer_pkg::RST_MAX_RANGE;
      cfg_r.min_range <= uer_pkg::RST_MIN_RANGE;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        uer_pkg::REG_MIN_INTERVAL: cfg_r.min_interval_ms <= cfg_data;
        uer_pkg::REG_RISE_TIMEOUT: cfg_r.rise_timeout_ms <= cfg_data[7:0];
        uer_pkg::REG_FALL_TIMEOUT: cfg_r.fall_timeout_ms <= cfg_data[7:0];
        uer_pkg::REG_SCALE:        cfg_r.scale_per_ms <= cfg_data[7:0];
        uer_pkg::REG_MAX_RANGE:    cfg_r.max_range <= cfg_data;
        uer_pkg::REG_MIN_RANGE:    cfg_r.min_range <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ST_IDLE;
      now_r <= '0;
      last_r <= '0;
      rise_r <= '0;
      deadline_r <= '0;
      pend_r <= 1'b0;
      dist_r <= 16'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      now_r <= now_nxt;
      last_r <= last_nxt;
      rise_r <= rise_nxt;
      deadline_r <= deadline_nxt;
      pend_r <= pend_nxt;
      dist_r <= dist_nxt;
      width_r <= width_nxt;
      if (accept) begin
        out_valid_r <= 1'b1;
        out_trig_r <= trig_nxt;
        out_done_r <= done_nxt;
        out_dist_r <= dist_nxt;
        out_phase_r <= phase_nxt;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.trigger_pulse = out_trig_r;
  assign out_chan.done_res = out_done_r;
  assign out_chan.distance_cm = out_dist_r;
  assign out_chan.phase = out_phase_r;

endmodule
`default_nettype wire

// File: rtl/uer_checker.sv
`default_nettype none
`include "ultrasonic_echo_ranger_unit_assert.svh"
module uer_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        in_valid,
  input wire        in_ready,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_trigger_pulse,
  input wire [15:0] out_distance_cm,
  input wire        out_done_res,
  input wire [2:0]  out_phase
);

  `UER_ASSERT_IMP(a_trig_phase, out_valid && out_trigger_pulse, out_phase == uer_pkg::PH_WAIT_RISE)
  `UER_ASSERT_IMP(a_done_idle, out_valid && out_done_res, out_phase == uer_pkg::PH_IDLE && !out_trigger_pulse)
  `UER_ASSERT_NXT(a_one_result, in_valid && in_ready, out_valid)
  `UER_ASSERT_NXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_distance_cm) && $stable(out_phase))

endmodule

bind ultrasonic_echo_ranger_unit uer_checker u_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_chan.valid),
  .in_ready          (in_chan.ready),
  .out_valid         (out_chan.valid),
  .out_ready         (out_chan.ready),
  .out_trigger_pulse (out_chan.trigger_pulse),
  .out_distance_cm   (out_chan.distance_cm),
  .out_done_res      (out_chan.done_res),
  .out_phase         (out_chan.phase)
);
`default_nettype wire
